[rtl/ffpa_pkg.sv]
// ffpa_pkg: shared types, constants and codes of the first-fit page allocator.
// No dependencies.
`default_nettype none
package ffpa_pkg;

    localparam int PROCESSES_DEF  = 8;
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [32:0] WINDOW_BYTES = 33'h0_2000_0000;
    localparam logic [32:0] ADDR_TOP     = 33'h1_0000_0000;

    // register word index (paddr[2])
    localparam logic [0:0] REG_HEAP_BASE = 1'b0;
    localparam logic [0:0] REG_USER_MASK = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_NOT_USER = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [2:0]  process_id;
        logic [29:0] request_bytes;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] start_address;
        logic [17:0] pages_granted;
    } t_out;

    // candidate travelling down the cell row
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [32:0] cand;
    } t_wave;

    // slot write broadcast to all cells
    typedef struct packed {
        logic        en;
        logic [5:0]  pidx;
        logic [7:0]  slot;
        logic [31:0] start;
        logic [32:0] end_addr;
    } t_wr;

endpackage
`default_nettype wire

[rtl/ffpa_cell.sv]
// ffpa_cell: one table slot for every process; checks the passing candidate
// against its block and hands it on. Depends on ffpa_pkg.
`default_nettype none
module ffpa_cell #(
    parameter int PROCESSES = ffpa_pkg::PROCESSES_DEF,
    parameter int IDX       = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [5:0]      i_pidx,
    input  wire logic [30:0]     i_size,
    input  wire ffpa_pkg::t_wr   i_wr,
    input  wire ffpa_pkg::t_wave i_wave,
    output ffpa_pkg::t_wave      o_wave
);
    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;

    logic [31:0]          r_start [PROCESSES];
    logic [32:0]          r_end   [PROCESSES];
    logic [PROCESSES-1:0] r_live;
    ffpa_pkg::t_wave      r_wave;
    ffpa_pkg::t_wave      n_wave;

    logic [PW-1:0] w_sel;
    logic [PW-1:0] w_rd;
    logic [33:0]   w_top;
    logic          w_ovl;

    assign w_sel = i_wr.pidx[PW-1:0];
    assign w_rd  = i_pidx[PW-1:0];
    assign w_top = {1'b0, i_wave.cand} + {3'b000, i_size};
    assign w_ovl = r_live[w_rd] &&
                   !(w_top <= {2'b00, r_start[w_rd]} || {1'b0, i_wave.cand} >= {1'b0, r_end[w_rd]});

    always_comb begin
        n_wave = i_wave;
        if (i_wave.valid && !i_wave.hit && w_ovl) begin
            n_wave.hit  = 1'b1;
            n_wave.cand = r_end[w_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= '0;
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= n_wave.valid;
            if (i_wr.en && i_wr.slot == 8'(IDX)) begin
                r_live[w_sel] <= 1'b1;
            end
        end
        r_wave.hit  <= n_wave.hit;
        r_wave.cand <= n_wave.cand;
        if (i_wr.en && i_wr.slot == 8'(IDX)) begin
            r_start[w_sel] <= i_wr.start;
            r_end[w_sel]   <= i_wr.end_addr;
        end
    end

    assign o_wave = r_wave;

    // a hit always moves the candidate strictly forward
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wave.valid && !i_wave.hit && w_ovl) |=> (r_wave.cand > $past(i_wave.cand)))
        else $error("cell hit did not advance candidate");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wave.valid && i_wave.hit) |=> (r_wave.hit && r_wave.cand == $past(i_wave.cand)))
        else $error("earlier hit altered in cell");
    a_vpass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wave.valid |=> r_wave.valid)
        else $error("wave lost in cell");

endmodule
`default_nettype wire

[rtl/first_fit_page_allocator.sv]
// first_fit_page_allocator: top level with APB registers, request control and
// the row of slot cells. Depends on ffpa_pkg and ffpa_cell.
//
//  channel   dir  handshake                    payload
//  request   in   i_in_valid / o_in_stall      i_in_data  (ffpa_pkg::t_in)
//  result    out  o_out_valid / i_out_stall    o_out_data (ffpa_pkg::t_out)
//  config    in   APB psel/penable/pwrite      paddr, pwdata, prdata
//
// One request at a time. A search pass sends the candidate down the cell row,
// through every cell in turn; each hit costs one more pass.
// Reset is synchronous; it clears all slot tables and counters at once.
// The result register holds while stalled; a new request is taken once the
// result is loaded into it.
`default_nettype none
module first_fit_page_allocator #(
    parameter int PROCESSES  = ffpa_pkg::PROCESSES_DEF,
    parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF,
    parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ffpa_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ffpa_pkg::t_out     o_out_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int PW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int UW  = $clog2(MAX_BLOCKS + 1);
    localparam int SH  = $clog2(PAGE_BYTES);
    localparam int NPW = 31 - SH;

    // configuration
    logic [31:0] r_heap_base;
    logic [7:0]  r_user_mask;

    // per-process counters
    logic [UW-1:0] r_used [PROCESSES];
    logic [31:0]   r_pin  [PROCESSES];

    ffpa_pkg::t_state r_state, n_state;
    logic [5:0]       r_pidx;
    logic [NPW-1:0]   r_npages;
    logic [30:0]      r_size;
    logic [32:0]      r_cand, n_cand;
    ffpa_pkg::t_out   r_res, n_res;
    ffpa_pkg::t_out   r_out;
    logic             r_out_valid;

    ffpa_pkg::t_wave  w_head;
    ffpa_pkg::t_wave  w_chain [MAX_BLOCKS+1];
    ffpa_pkg::t_wr    w_wr;

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_user;
    logic [30:0] w_round;
    logic [32:0] w_win_raw;
    logic [32:0] w_win_end;
    logic [33:0] w_top;
    logic        w_full;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_user_mask <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2:2])
                ffpa_pkg::REG_HEAP_BASE: r_heap_base <= pwdata;
                ffpa_pkg::REG_USER_MASK: r_user_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2:2])
            ffpa_pkg::REG_HEAP_BASE: prdata = r_heap_base;
            ffpa_pkg::REG_USER_MASK: prdata = {24'd0, r_user_mask};
            default:                 prdata = '0;
        endcase
    end

    assign o_in_stall = (r_state != ffpa_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_user     = ({4'b0000, i_in_data.process_id} < 7'(PROCESSES)) &&
                        r_user_mask[i_in_data.process_id];
    assign w_round    = {1'b0, i_in_data.request_bytes} + 31'(PAGE_BYTES - 1);

    assign w_win_raw = {1'b0, r_heap_base} + ffpa_pkg::WINDOW_BYTES;
    assign w_win_end = (w_win_raw > ffpa_pkg::ADDR_TOP) ? ffpa_pkg::ADDR_TOP : w_win_raw;
    assign w_top     = {1'b0, r_cand} + {3'b000, r_size};
    assign w_full    = (r_used[r_pidx[PW-1:0]] >= UW'(MAX_BLOCKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cand        = r_cand;
        n_res         = r_res;
        w_head        = '0;
        w_wr          = '0;
        w_wr.pidx     = r_pidx;
        w_wr.slot     = 8'(r_used[r_pidx[PW-1:0]]);
        w_wr.start    = r_cand[31:0];
        w_wr.end_addr = {1'b0, r_cand[31:0]} + {2'b00, r_size};
        unique case (r_state)
            ffpa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_cand = {1'b0, r_heap_base};
                    n_res  = '0;
                    if (w_user) begin
                        n_state = ffpa_pkg::S_CHECK;
                    end else begin
                        n_res.status = ffpa_pkg::ST_NOT_USER;
                        n_state      = ffpa_pkg::S_RESULT;
                    end
                end
            end
            ffpa_pkg::S_CHECK: begin
                if (w_top > {1'b0, w_win_end}) begin
                    n_res.status = ffpa_pkg::ST_NO_ROOM;
                    n_state      = ffpa_pkg::S_RESULT;
                end else begin
                    w_head.valid = 1'b1;
                    w_head.cand  = r_cand;
                    n_state      = ffpa_pkg::S_WAIT;
                end
            end
            ffpa_pkg::S_WAIT: begin
                if (w_chain[MAX_BLOCKS].valid) begin
                    if (w_chain[MAX_BLOCKS].hit) begin
                        n_cand  = w_chain[MAX_BLOCKS].cand;
                        n_state = ffpa_pkg::S_CHECK;
                    end else if (w_full) begin
                        n_res.status = ffpa_pkg::ST_FULL;
                        n_state      = ffpa_pkg::S_RESULT;
                    end else begin
                        w_wr.en             = 1'b1;
                        n_res.status        = ffpa_pkg::ST_GRANTED;
                        n_res.start_address = r_cand[31:0];
                        n_res.pages_granted = 18'(r_npages);
                        n_state             = ffpa_pkg::S_RESULT;
                    end
                end
            end
            ffpa_pkg::S_RESULT: begin
                if (w_out_free) begin
                    n_state = ffpa_pkg::S_IDLE;
                end
            end
            default: n_state = ffpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_res  <= n_res;
        if (w_in_acc) begin
            r_pidx   <= 6'(i_in_data.process_id);
            r_npages <= w_round[30:SH];
            r_size   <= {w_round[30:SH], {SH{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PROCESSES; p++) begin
                r_used[p] <= '0;
                r_pin[p]  <= '0;
            end
        end else if (w_wr.en) begin
            r_used[r_pidx[PW-1:0]] <= r_used[r_pidx[PW-1:0]] + UW'(1);
            r_pin[r_pidx[PW-1:0]]  <= r_pin[r_pidx[PW-1:0]] + 32'(r_npages);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= (r_state == ffpa_pkg::S_RESULT);
        end
        if (w_out_free && r_state == ffpa_pkg::S_RESULT) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_chain[0] = w_head;
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffpa_cell #(
            .PROCESSES (PROCESSES),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pidx  (r_pidx),
            .i_size  (r_size),
            .i_wr    (w_wr),
            .i_wave  (w_chain[g]),
            .o_wave  (w_chain[g+1])
        );
    end

    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[MAX_BLOCKS].valid |-> (r_state == ffpa_pkg::S_WAIT))
        else $error("candidate left the row outside a search");
    a_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ffpa_pkg::ST_GRANTED) |->
        (o_out_data.start_address == 32'd0 && o_out_data.pages_granted == 18'd0))
        else $error("refused result carries address or pages");
    a_nofull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> !w_full)
        else $error("slot written into a full table");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != ffpa_pkg::S_IDLE))
        else $error("request taken but controller idle");

endmodule
`default_nettype wire
